// File: rtl/core/framed_packet_receiver_top_macros.svh
// assertion macros for the framed packet receiver
`ifndef FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fpr_pkg.sv
// shared types and constants for the framed packet receiver
package fpr_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  localparam logic [2:0] ST_IN_FRAME = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_CKSUM    = 3'd2;
  localparam logic [2:0] ST_BAD_LEN  = 3'd3;
  localparam logic [2:0] ST_GARBAGE  = 3'd4;

  localparam logic [7:0] TYPE_STORAGE = 8'h01;
  localparam logic [7:0] TYPE_SUPPLY  = 8'h02;
  localparam logic [7:0] TYPE_STOP    = 8'h04;
  localparam logic [7:0] TYPE_RESUME  = 8'h05;

  localparam logic [7:0] MIN_LEN      = 8'd5;
  localparam logic [7:0] DATA_MIN_LEN = 8'd6;
  localparam logic [7:0] CKSUM_BASE   = 8'hFF;

  localparam logic [7:0] POS_TYPE  = 8'd2;
  localparam logic [7:0] POS_DEST  = 8'd4;
  localparam logic [7:0] POS_DATA  = 8'd5;

  localparam logic       CFG_START = 1'b0;
  localparam logic       CFG_TEAM  = 1'b1;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_kind;
    logic [7:0] storage_avail;
    logic [7:0] supply_avail;
    logic       stop_requested;
    logic       pause_pulse;
    logic       resume_pulse;
  } result_t;

endpackage

// File: rtl/core/fpr_parser.sv
// frame parser state and per-byte next-state logic
module fpr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic [7:0]      start_byte,
  input  logic [7:0]      team_address,
  output fpr_pkg::result_t res
);

  fpr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic [7:0] held_type_r, held_type_nxt;
  logic [7:0] held_dest_r, held_dest_nxt;
  logic [7:0] held_data_r, held_data_nxt;
  logic [7:0] storage_r, storage_nxt;
  logic [7:0] supply_r, supply_nxt;
  logic       stop_r, stop_nxt;
  logic [2:0] status;
  logic [7:0] kind;
  logic       pause;
  logic       resume;

  always_comb begin
    phase_nxt        = phase_r;
    byte_index_nxt   = byte_index_r;
    frame_length_nxt = frame_length_r;
    running_sum_nxt  = running_sum_r;
    held_type_nxt    = held_type_r;
    held_dest_nxt    = held_dest_r;
    held_data_nxt    = held_data_r;
    storage_nxt      = storage_r;
    supply_nxt       = supply_r;
    stop_nxt         = stop_r;
    status           = fpr_pkg::ST_IN_FRAME;
    kind             = 8'd0;
    pause            = 1'b0;
    resume           = 1'b0;
    case (phase_r)
      fpr_pkg::PH_LEN: begin
        if (in_byte < fpr_pkg::MIN_LEN) begin
          status    = fpr_pkg::ST_BAD_LEN;
          phase_nxt = fpr_pkg::PH_HUNT;
        end else begin
          frame_length_nxt = in_byte;
          running_sum_nxt  = in_byte;
          byte_index_nxt   = fpr_pkg::POS_TYPE;
          phase_nxt        = fpr_pkg::PH_BODY;
        end
      end
      fpr_pkg::PH_BODY: begin
        if (byte_index_r >= frame_length_r) begin
          kind      = held_type_r;
          phase_nxt = fpr_pkg::PH_HUNT;
          if (fpr_pkg::CKSUM_BASE - running_sum_r == in_byte) begin
            status = fpr_pkg::ST_ACCEPT;
            case (held_type_r)
              fpr_pkg::TYPE_STORAGE: begin
                if (frame_length_r >= fpr_pkg::DATA_MIN_LEN) storage_nxt = held_data_r;
              end
              fpr_pkg::TYPE_SUPPLY: begin
                if (frame_length_r >= fpr_pkg::DATA_MIN_LEN) supply_nxt = held_data_r;
              end
              fpr_pkg::TYPE_STOP: begin
                if (held_dest_r == team_address) begin
                  stop_nxt = 1'b1;
                  pause    = 1'b1;
                end
              end
              fpr_pkg::TYPE_RESUME: begin
                if (held_dest_r == team_address) begin
                  stop_nxt = 1'b0;
                  resume   = 1'b1;
                end
              end
              default: ;
            endcase
          end else begin
            status = fpr_pkg::ST_CKSUM;
          end
        end else begin
          running_sum_nxt = running_sum_r + in_byte;
          if (byte_index_r == fpr_pkg::POS_TYPE) held_type_nxt = in_byte;
          else if (byte_index_r == fpr_pkg::POS_DEST) held_dest_nxt = in_byte;
          else if (byte_index_r == fpr_pkg::POS_DATA) held_data_nxt = in_byte;
          byte_index_nxt = byte_index_r + 8'd1;
        end
      end
      default: begin
        if (in_byte == start_byte) begin
          phase_nxt = fpr_pkg::PH_LEN;
        end else begin
          phase_nxt = fpr_pkg::PH_HUNT;
          status    = fpr_pkg::ST_GARBAGE;
        end
      end
    endcase
  end

  always_comb begin
    res.status         = status;
    res.frame_kind     = kind;
    res.storage_avail  = storage_nxt;
    res.supply_avail   = supply_nxt;
    res.stop_requested = stop_nxt;
    res.pause_pulse    = pause;
    res.resume_pulse   = resume;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= fpr_pkg::PH_HUNT;
      byte_index_r   <= 8'd0;
      frame_length_r <= 8'd0;
      running_sum_r  <= 8'd0;
      held_type_r    <= 8'd0;
      held_dest_r    <= 8'd0;
      held_data_r    <= 8'd0;
      storage_r      <= 8'd0;
      supply_r       <= 8'd0;
      stop_r         <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      byte_index_r   <= byte_index_nxt;
      frame_length_r <= frame_length_nxt;
      running_sum_r  <= running_sum_nxt;
      held_type_r    <= held_type_nxt;
      held_dest_r    <= held_dest_nxt;
      held_data_r    <= held_data_nxt;
      storage_r      <= storage_nxt;
      supply_r       <= supply_nxt;
      stop_r         <= stop_nxt;
    end
  end

endmodule

// File: rtl/core/fpr_out_reg.sv
// result register with stream handshake toward the sink
module fpr_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  fpr_pkg::result_t res_in,
  input  logic             out_tready,
  output logic             out_tvalid,
  output fpr_pkg::result_t res_out,
  output logic             can_load
);

  logic             valid_r, valid_nxt;
  fpr_pkg::result_t res_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign res_out    = res_r;

endmodule

// File: rtl/core/framed_packet_receiver_top.sv
// top level of the framed packet receiver
//
//   port group   dir  contents
//   in_*         in   one received byte per transaction
//   out_*        out  one status result per accepted byte
//   cfg_*        in   register writes: 0 start byte, 1 team address
//
// a byte per cycle unless stalled; a result appears the cycle after its byte is taken
// throughput is bounded only by the single result register
// in_tready drops only while a result is held and out_tready is low
// rst_n clears parser state and the result valid; start byte 95, team address 1
module framed_packet_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status, frame_kind, storage_avail, supply_avail,
                                  // stop_requested, pause_pulse, resume_pulse, zero fill
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]       start_byte_r;
  logic [7:0]       team_address_r;
  logic             accept;
  logic             can_load;
  fpr_pkg::result_t res;
  fpr_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r   <= 8'd95;
      team_address_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        fpr_pkg::CFG_START: start_byte_r   <= cfg_wdata;
        fpr_pkg::CFG_TEAM:  team_address_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  fpr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_tdata),
    .start_byte   (start_byte_r),
    .team_address (team_address_r),
    .res          (res)
  );

  fpr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res_in     (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_out    (res_q),
    .can_load   (can_load)
  );

  assign out_tdata = {2'b00, res_q.resume_pulse, res_q.pause_pulse, res_q.stop_requested,
                      res_q.supply_avail, res_q.storage_avail, res_q.frame_kind,
                      res_q.status};

`include "framed_packet_receiver_top_macros.svh"

  `FPR_ASSERT_NXT(a_byte_gives_result, clk, rst_n, in_tvalid && in_tready, out_tvalid, "accepted byte gave no result")
  `FPR_ASSERT_IMP(a_pause_sets_stop, clk, rst_n, out_tvalid && res_q.pause_pulse, res_q.stop_requested && !res_q.resume_pulse, "pause without stop flag")
  `FPR_ASSERT_IMP(a_resume_clears_stop, clk, rst_n, out_tvalid && res_q.resume_pulse, !res_q.stop_requested && res_q.status == fpr_pkg::ST_ACCEPT, "resume with stop flag set")
  `FPR_ASSERT_IMP(a_kind_on_frame_end, clk, rst_n, out_tvalid && res_q.frame_kind != 8'd0, res_q.status == fpr_pkg::ST_ACCEPT || res_q.status == fpr_pkg::ST_CKSUM, "frame kind outside frame end")

endmodule
